>>> design/ttc_pkg.sv
// ttc_pkg: shared types and constants for the triangle tangent block
// holds the request structs, controller states and the controller/datapath command struct
// no dependencies
`default_nettype none

package ttc_pkg;

  // coordinate format: signed fixed point, fraction width set per instance
  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // sign and magnitude of a coordinate difference
  typedef logic [COORD_WIDTH:0] smag_t;

  // one corner request
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
  } in_item_t;

  // one tangent result
  typedef struct packed {
    coord_t tangent_x;
    coord_t tangent_y;
    coord_t tangent_z;
    logic   degenerate;
    logic   saturated;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DET,
    S_DSETUP,
    S_DIV,
    S_DFIN,
    S_OUT
  } ctl_state_t;

  // tangent component select
  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      hold_wr;
    logic      hold_idx;
    logic      diff_en;
    logic      mul_en;
    logic      mul_term;
    logic      mul_det;
    logic      acc_en;
    logic      acc_clr;
    logic      det_ld;
    logic      div_init;
    logic      div_step;
    logic      comp_wr;
    comp_sel_t comp;
    logic      out_ld;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic acc_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/ttc_ctrl.sv
// ttc_ctrl: sequencer for the triangle tangent block
// counts corners, steps the multiply-accumulate and divider, owns the handshakes
// depends on ttc_pkg
`default_nettype none

module ttc_ctrl
  import ttc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = $clog2(W);

  ctl_state_t      state_r, state_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0]      step_r, step_nxt;
  comp_sel_t       comp_r, comp_nxt;
  logic            is_det_r, is_det_nxt;
  logic [CW-1:0]   bit_r, bit_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic in_acc;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      step_r      <= 2'd0;
      comp_r      <= COMP_X;
      is_det_r    <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      comp_r      <= comp_nxt;
      is_det_r    <= is_det_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    comp_nxt      = comp_r;
    is_det_nxt    = is_det_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_r == 2'd2) begin
            cnt_nxt    = 2'd0;
            step_nxt   = 2'd0;
            is_det_nxt = 1'b1;
            state_nxt  = S_MAC;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_MAC: begin
        if (step_r == 2'd2) begin
          step_nxt  = 2'd0;
          state_nxt = is_det_r ? S_DET : S_DSETUP;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      S_DET: begin
        if (stat.acc_zero) begin
          state_nxt = S_OUT;
        end else begin
          is_det_nxt = 1'b0;
          comp_nxt   = COMP_X;
          state_nxt  = S_MAC;
        end
      end
      S_DSETUP: begin
        bit_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (bit_r == CW'(W - 1)) begin
          state_nxt = S_DFIN;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_DFIN: begin
        unique case (comp_r)
          COMP_X: begin
            comp_nxt  = COMP_Y;
            state_nxt = S_MAC;
          end
          COMP_Y: begin
            comp_nxt  = COMP_Z;
            state_nxt = S_MAC;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.comp     = comp_r;
    cmd.hold_idx = cnt_r[0];
    cmd.mul_det  = is_det_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.hold_wr = in_acc && (cnt_r != 2'd2);
        cmd.diff_en = in_acc && (cnt_r == 2'd2);
      end
      S_MAC: begin
        cmd.mul_en   = (step_r != 2'd2);
        cmd.mul_term = step_r[0];
        cmd.acc_en   = (step_r != 2'd0);
        cmd.acc_clr  = (step_r == 2'd1);
      end
      S_DET: begin
        cmd.det_ld = 1'b1;
      end
      S_DSETUP: begin
        cmd.div_init = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_DFIN: begin
        cmd.comp_wr = 1'b1;
      end
      S_OUT: begin
        cmd.out_ld = out_free;
      end
      default: begin
      end
    endcase
  end

  // third corner starts the determinant
  a_third_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && cnt_r == 2'd2) |=>
      (state_r == S_MAC && is_det_r && step_r == 2'd0))
    else $error("third corner did not start the determinant");

  // the corner count is idle while a triangle is in work
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r == 2'd0))
    else $error("corner count not cleared during triangle work");

  // a result appears only from the output state
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");

  // a component finishes only after the full divider run
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFIN) |-> ($past(state_r) == S_DIV && $past(bit_r) == CW'(W - 1)))
    else $error("divider run cut short");

  // the hold, delta, determinant, divider, component and output loads never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.hold_wr, cmd.diff_en, cmd.det_ld, cmd.div_init,
              cmd.div_step, cmd.comp_wr, cmd.out_ld}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

>>> design/ttc_dpath.sv
// ttc_dpath: datapath of the triangle tangent block
// corner hold registers, edge deltas, shared multiplier with accumulator,
// restoring divider, saturation and the output register; depends on ttc_pkg
`default_nettype none

module ttc_dpath
  import ttc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = 2 * W + 2;
  localparam int SHR = W - FRAC_BITS;

  in_item_t               hold_r [2];
  smag_t                  e1_r [3];
  smag_t                  e2_r [3];
  smag_t                  du1_r, dv1_r, du2_r, dv2_r;
  logic [2*W-1:0]         prod_r;
  logic                   prod_neg_r;
  logic signed [AW-1:0]   acc_r;
  logic                   det_neg_r;
  logic [AW-1:0]          det_mag_r;
  logic [AW-1:0]          rem_r;
  logic [W-1:0]           quo_r;
  logic                   big_r;
  logic                   num_neg_r;
  logic [W-1:0]           tang_r [3];
  logic                   degen_r;
  logic                   sat_r;
  out_item_t              out_data_r;

  smag_t                  op_a, op_b;
  logic [2*W-1:0]         mul_p;
  logic signed [AW-1:0]   addend;
  logic [AW-1:0]          acc_u, acc_mag, r0;
  logic [AW:0]            r2, r2_sub;
  logic                   r2_ge;
  logic                   res_neg, res_sat;
  logic [W-1:0]           lim, res_mag, res_val;

  // signed difference as sign and magnitude
  function automatic smag_t sdiff(input coord_t a, input coord_t b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    sdiff = {d[W], (d[W] ? W'(-d) : d[W-1:0])};
  endfunction

  // first two corners of the triangle
  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      hold_r[cmd.hold_idx] <= in_data;
    end
  end

  // edges and uv deltas, taken as the third corner arrives
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      e1_r[0] <= sdiff(hold_r[1].pos_x, hold_r[0].pos_x);
      e1_r[1] <= sdiff(hold_r[1].pos_y, hold_r[0].pos_y);
      e1_r[2] <= sdiff(hold_r[1].pos_z, hold_r[0].pos_z);
      e2_r[0] <= sdiff(in_data.pos_x, hold_r[0].pos_x);
      e2_r[1] <= sdiff(in_data.pos_y, hold_r[0].pos_y);
      e2_r[2] <= sdiff(in_data.pos_z, hold_r[0].pos_z);
      du1_r   <= sdiff(hold_r[1].tex_u, hold_r[0].tex_u);
      dv1_r   <= sdiff(hold_r[1].tex_v, hold_r[0].tex_v);
      du2_r   <= sdiff(in_data.tex_u, hold_r[0].tex_u);
      dv2_r   <= sdiff(in_data.tex_v, hold_r[0].tex_v);
    end
  end

  // multiplier operand select
  always_comb begin
    if (cmd.mul_det) begin
      op_a = cmd.mul_term ? du2_r : du1_r;
      op_b = cmd.mul_term ? dv1_r : dv2_r;
    end else begin
      op_a = cmd.mul_term ? dv1_r : dv2_r;
      case (cmd.comp)
        COMP_X:  op_b = cmd.mul_term ? e2_r[0] : e1_r[0];
        COMP_Y:  op_b = cmd.mul_term ? e2_r[1] : e1_r[1];
        default: op_b = cmd.mul_term ? e2_r[2] : e1_r[2];
      endcase
    end
    mul_p = op_a[W-1:0] * op_b[W-1:0];
  end

  // product register, second term subtracted
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= mul_p;
      prod_neg_r <= op_a[W] ^ op_b[W] ^ cmd.mul_term;
    end
  end

  // accumulator
  assign addend = prod_neg_r ? -$signed({2'b00, prod_r}) : $signed({2'b00, prod_r});

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= (cmd.acc_clr ? AW'(0) : acc_r) + addend;
    end
  end

  assign acc_u         = acc_r;
  assign acc_mag       = acc_u[AW-1] ? (AW'(0) - acc_u) : acc_u;
  assign stat.acc_zero = (acc_u == '0);

  // divider: remainder starts with the bits above the quotient window
  assign r0     = acc_mag >> SHR;
  assign r2     = {rem_r, quo_r[W-1]};
  assign r2_sub = r2 - {1'b0, det_mag_r};
  assign r2_ge  = (r2 >= {1'b0, det_mag_r});

  always_ff @(posedge clk) begin
    if (cmd.det_ld) begin
      det_neg_r <= acc_u[AW-1];
      det_mag_r <= acc_mag;
    end
    if (cmd.div_init) begin
      rem_r     <= r0;
      big_r     <= (r0 >= det_mag_r);
      quo_r     <= {acc_mag[SHR-1:0], {FRAC_BITS{1'b0}}};
      num_neg_r <= acc_u[AW-1];
    end else if (cmd.div_step) begin
      rem_r <= r2_ge ? r2_sub[AW-1:0] : r2[AW-1:0];
      quo_r <= {quo_r[W-2:0], r2_ge};
    end
  end

  // sign, clip to range
  always_comb begin
    res_neg = num_neg_r ^ det_neg_r;
    lim     = res_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    res_sat = big_r || (quo_r > lim);
    res_mag = res_sat ? lim : quo_r;
    res_val = res_neg ? (W'(0) - res_mag) : res_mag;
  end

  // tangent and flags of the current triangle
  always_ff @(posedge clk) begin
    if (cmd.det_ld) begin
      tang_r[0] <= '0;
      tang_r[1] <= '0;
      tang_r[2] <= '0;
      degen_r   <= (acc_u == '0);
      sat_r     <= 1'b0;
    end else if (cmd.comp_wr) begin
      case (cmd.comp)
        COMP_X:  tang_r[0] <= res_val;
        COMP_Y:  tang_r[1] <= res_val;
        default: tang_r[2] <= res_val;
      endcase
      sat_r <= sat_r | res_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r.tangent_x  <= tang_r[0];
      out_data_r.tangent_y  <= tang_r[1];
      out_data_r.tangent_z  <= tang_r[2];
      out_data_r.degenerate <= degen_r;
      out_data_r.saturated  <= sat_r;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> design/triangle_tangent_calc.sv
// triangle_tangent_calc: per-triangle tangent from a stream of corner requests
// result: a degenerate triangle (zero determinant) skips the divider and goes straight to output
// flow: one triangle at a time, no corner is taken until its result is loaded; the work is set by the 32-step
//   restoring divider run once per tangent component; the first two corners are only held while idle
// reset: clears the sequencer, corner count and result valid; held corners are not cleared
// depends on ttc_pkg, ttc_ctrl, ttc_dpath
`default_nettype none

module triangle_tangent_calc
  import ttc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and storage
  ttc_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
